// ===== hw/rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Codes and controller/datapath interface types of the page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Width used for zone, run and frame range arithmetic.
	localparam int AW = 22;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FREE  = 2'd1;
	localparam logic [1:0] FUNC_OWN   = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OOM     = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_FREE    = 3'd3;
	localparam logic [2:0] ST_REFUSED = 3'd4;

	localparam logic CFG_ZONE_BASE  = 1'b0;
	localparam logic CFG_ZONE_COUNT = 1'b1;

	typedef struct packed {
		logic       load;
		logic       clr_wr;
		logic       rd;
		logic       adv_start;
		logic       adv_off;
		logic       clr_off;
		logic       mark_wr;
		logic       dec_wr;
		logic       own_wr;
		logic       set_status;
		logic [2:0] code;
		logic       take_frame;
		logic       push;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic n_zero;
		logic cand_fits;
		logic cand_aligned;
		logic rd_busy;
		logic rd_one;
		logic owner_zero;
		logic off_last;
		logic off_end;
		logic in_zone;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/contiguous_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top
// First-fit contiguous page-frame allocator over one RAM zone.
// ----------------------------------------------------------------------------
// Items enter on the in_valid/in_ready channel and each gives one result item
// on out_valid/out_ready. The user must set the zone through cfg_we, cfg_index
// and cfg_wdata only while the block is idle; the block does not enforce it.
// One item is worked on at a time by a sequencer over count and owner stores
// with one write port each and registered reads. Alloc probes each page with a
// read and then a test, restarting at the next start after a busy page, and
// skips each start that is not aligned; it then writes the run at one page a
// cycle. Free reads and tests each page in the zone and passes over pages
// outside it; Own reads and tests its frame unless it lies outside the zone; an
// unknown operation goes straight to the finishing step. The result becomes
// valid in the same cycle as the next item can be accepted. After reset the
// count store is cleared, one entry a cycle, until every entry is zero; in_ready
// stays low meanwhile. A finished result waits in the output register; while
// the receiver stalls the next item is still accepted and worked on, and it
// holds in the finishing step until the output is free.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_top #(
	parameter int ZONE_SLOTS = 1024,
	parameter int OWNER_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [10:0] page_count,
	input  logic [7:0]  owner_id,
	input  logic        align_request,
	input  logic [19:0] frame_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [19:0] alloc_frame
);

	cpa_pkg::cmd_t cmd;
	cpa_pkg::sts_t sts;

	cpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpa_dp #(
		.ZONE_SLOTS (ZONE_SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.page_count    (page_count),
		.owner_id      (owner_id),
		.align_request (align_request),
		.frame_address (frame_address),
		.func          (func),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.alloc_frame   (alloc_frame),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== hw/rtl/cpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer for the clearing pass, alloc search and marking, free and own.
// ----------------------------------------------------------------------------
module cpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  cpa_pkg::sts_t sts,
	output cpa_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_CHK, S_A_TST, S_A_MARK,
		S_F_CHK, S_F_TST, S_O_CHK, S_O_TST, S_FINISH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (func)
						cpa_pkg::FUNC_ALLOC: state_d = S_A_CHK;
						cpa_pkg::FUNC_FREE:  state_d = S_F_CHK;
						cpa_pkg::FUNC_OWN:   state_d = S_O_CHK;
						default:             state_d = S_FINISH;
					endcase
				end
			end
			S_A_CHK: begin
				if (sts.n_zero || !sts.cand_fits) begin
					cmd.set_status = 1'b1;
					cmd.code       = cpa_pkg::ST_OOM;
					state_d        = S_FINISH;
				end else if (!sts.cand_aligned) begin
					cmd.adv_start = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_A_TST;
				end
			end
			S_A_TST: begin
				if (sts.rd_busy) begin
					cmd.adv_start = 1'b1;
					state_d       = S_A_CHK;
				end else if (sts.off_last) begin
					cmd.clr_off = 1'b1;
					state_d     = S_A_MARK;
				end else begin
					cmd.adv_off = 1'b1;
					state_d     = S_A_CHK;
				end
			end
			S_A_MARK: begin
				cmd.mark_wr = 1'b1;
				if (sts.off_last) begin
					cmd.take_frame = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cmd.adv_off = 1'b1;
				end
			end
			S_F_CHK: begin
				if (sts.off_end) begin
					state_d = S_FINISH;
				end else if (!sts.in_zone) begin
					cmd.set_status = 1'b1;
					cmd.code       = cpa_pkg::ST_OUTSIDE;
					cmd.adv_off    = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_F_TST;
				end
			end
			S_F_TST: begin
				if (sts.rd_busy) begin
					cmd.dec_wr = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.code       = cpa_pkg::ST_FREE;
				end
				cmd.adv_off = 1'b1;
				state_d     = S_F_CHK;
			end
			S_O_CHK: begin
				if (!sts.in_zone) begin
					cmd.set_status = 1'b1;
					cmd.code       = cpa_pkg::ST_OUTSIDE;
					state_d        = S_FINISH;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_O_TST;
				end
			end
			S_O_TST: begin
				if (sts.rd_one && sts.owner_zero) begin
					cmd.own_wr = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.code       = cpa_pkg::ST_REFUSED;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/cpa_dp.sv =====
// ----------------------------------------------------------------------------
// cpa_dp
// Datapath: zone registers, count and owner stores, counters, result register.
// ----------------------------------------------------------------------------
module cpa_dp #(
	parameter int ZONE_SLOTS = 1024,
	parameter int OWNER_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [19:0]   cfg_wdata,
	input  logic [10:0]   page_count,
	input  logic [7:0]    owner_id,
	input  logic          align_request,
	input  logic [19:0]   frame_address,
	input  logic [1:0]    func,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [19:0]   alloc_frame,
	input  cpa_pkg::cmd_t cmd,
	output cpa_pkg::sts_t sts
);

	localparam int AW = cpa_pkg::AW;
	localparam int IW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
	localparam int CW = $clog2(ZONE_SLOTS + 1);

	logic [19:0] base_q;
	logic [10:0] zpc_q;

	logic [1:0]  func_q;
	logic [10:0] n_q;
	logic [7:0]  owner_q;
	logic        align_q;
	logic [19:0] frame_q;
	logic [CW-1:0] start_q;
	logic [10:0] off_q;
	logic [IW-1:0] clr_q;
	logic [2:0]  status_q;
	logic [19:0] res_frame_q;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [19:0] out_frame_q;

	logic [7:0]            ref_mem [ZONE_SLOTS];
	logic [OWNER_BITS-1:0] own_mem [ZONE_SLOTS];
	logic [7:0]            rdata_q;
	logic [OWNER_BITS-1:0] odata_q;

	logic [AW-1:0] zlen, run_end, a_sum, f_sum, f_off, fr_sum;
	logic [IW-1:0] a_addr, f_addr, rd_addr, ref_wa, own_wa;
	logic [19:0]   cand_frame;
	logic [7:0]    ref_wd;
	logic          ref_we, own_we;
	logic [15:0]   owner_ext;
	logic [OWNER_BITS-1:0] own_wd;

	always_comb begin
		zlen = ({11'd0, zpc_q} > AW'(ZONE_SLOTS)) ? AW'(ZONE_SLOTS) : AW'(zpc_q);
		run_end    = AW'(start_q) + AW'(n_q);
		a_sum      = AW'(start_q) + AW'(off_q);
		a_addr     = a_sum[IW-1:0];
		f_sum      = AW'(frame_q) + AW'(off_q);
		f_off      = f_sum - AW'(base_q);
		f_addr     = f_off[IW-1:0];
		fr_sum     = AW'(base_q) + AW'(start_q);
		cand_frame = fr_sum[19:0];
		rd_addr    = (func_q == cpa_pkg::FUNC_ALLOC) ? a_addr : f_addr;
		owner_ext  = {8'd0, owner_q};
		own_wd     = owner_ext[OWNER_BITS-1:0];
	end

	always_comb begin
		sts.clr_done     = (clr_q == IW'(ZONE_SLOTS - 1));
		sts.n_zero       = (n_q == 11'd0);
		sts.cand_fits    = (run_end <= zlen);
		sts.cand_aligned = !align_q || ((cand_frame[10:0] & (n_q - 11'd1)) == 11'd0);
		sts.rd_busy      = (rdata_q != 8'd0);
		sts.rd_one       = (rdata_q == 8'd1);
		sts.owner_zero   = (odata_q == '0);
		sts.off_last     = ((off_q + 11'd1) == n_q);
		sts.off_end      = (off_q == n_q);
		sts.in_zone      = (f_sum >= AW'(base_q)) && (f_off < zlen);
		sts.out_free     = !out_valid_q || out_ready;
	end

	// One write port per store: count clear, mark and decrement share it.
	always_comb begin
		ref_we = cmd.clr_wr || cmd.mark_wr || cmd.dec_wr;
		ref_wa = cmd.clr_wr ? clr_q : (cmd.mark_wr ? a_addr : f_addr);
		ref_wd = cmd.clr_wr ? 8'd0 : (cmd.mark_wr ? 8'd1 : rdata_q - 8'd1);
		own_we = cmd.mark_wr || cmd.own_wr;
		own_wa = cmd.mark_wr ? a_addr : f_addr;
	end

	always_ff @(posedge clk) begin
		if (ref_we) ref_mem[ref_wa] <= ref_wd;
		if (own_we) own_mem[own_wa] <= own_wd;
		if (cmd.rd) begin
			rdata_q <= ref_mem[rd_addr];
			odata_q <= own_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			n_q     <= page_count;
			owner_q <= owner_id;
			align_q <= align_request;
			frame_q <= frame_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			zpc_q        <= '0;
			clr_q        <= '0;
			start_q      <= '0;
			off_q        <= '0;
			status_q     <= cpa_pkg::ST_OK;
			res_frame_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= cpa_pkg::ST_OK;
			out_frame_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == cpa_pkg::CFG_ZONE_BASE) base_q <= cfg_wdata;
				else zpc_q <= cfg_wdata[10:0];
			end
			if (cmd.clr_wr) clr_q <= clr_q + IW'(1);
			if (cmd.load) begin
				start_q     <= '0;
				off_q       <= '0;
				status_q    <= cpa_pkg::ST_OK;
				res_frame_q <= '0;
			end else begin
				if (cmd.adv_start) begin
					start_q <= start_q + CW'(1);
					off_q   <= '0;
				end else if (cmd.clr_off) begin
					off_q <= '0;
				end else if (cmd.adv_off) begin
					off_q <= off_q + 11'd1;
				end
				// Only the first fault of a free range is reported.
				if (cmd.set_status && status_q == cpa_pkg::ST_OK) status_q <= cmd.code;
				if (cmd.take_frame) res_frame_q <= cand_frame;
			end
			if (cmd.push) begin
				out_valid_q  <= 1'b1;
				out_status_q <= status_q;
				out_frame_q  <= res_frame_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign alloc_frame = out_frame_q;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || out_ready))
		else $error("result pushed over an untaken item");
	a_mark_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> (sts.cand_fits && !sts.n_zero))
		else $error("marking a run that leaves the zone");
	a_fault_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.load && status_q != cpa_pkg::ST_OK) |=> (status_q == $past(status_q)))
		else $error("first fault overwritten");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contiguous page-frame allocator.
// ----------------------------------------------------------------------------
// A queue of requests is filled zone setting by zone setting. A clocked driver
// offers them in bursts. At each accepted request a behavioural model of the
// zone, with its own count and owner stores, works out the expected status and
// frame. A clocked monitor compares each result with the oldest expectation.
// The zone is reprogrammed between settings, once all results have come back.
// ----------------------------------------------------------------------------
module tb;

	localparam int          PAGES      = 1024;
	localparam logic [1:0]  FUNC_NONE  = 2'd3;
	localparam int unsigned CYCLE_CAP  = 20_000_000;

	typedef struct {
		logic [1:0]  op;
		logic [10:0] npages;
		logic [7:0]  owner;
		logic        align;
		logic [19:0] frame;
	} page_req_t;

	typedef struct {
		logic [2:0]  code;
		logic [19:0] first_frame;
	} page_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [19:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [10:0] page_count;
	logic [7:0]  owner_id;
	logic        align_request;
	logic [19:0] frame_address;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [19:0] alloc_frame;

	contiguous_page_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .page_count(page_count), .owner_id(owner_id),
		.align_request(align_request), .frame_address(frame_address),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .alloc_frame(alloc_frame)
	);

	// Zone model.
	int unsigned zone_base;
	int unsigned zone_pages;
	byte unsigned page_refs[PAGES];
	byte unsigned page_owner[PAGES];

	page_req_t   pending_reqs[$];
	page_res_t   awaited_results[$];
	page_req_t   offered;
	int          mismatches;
	int unsigned cycle_count;

	function automatic int unsigned zone_len();
		return (zone_pages > PAGES) ? PAGES : zone_pages;
	endfunction

	function automatic int zone_slot(int unsigned f);
		if (f < zone_base || f - zone_base >= zone_len())
			return -1;
		return int'(f - zone_base);
	endfunction

	function automatic page_res_t model_request(page_req_t r);
		page_res_t   res;
		int unsigned len;
		int unsigned n;
		int unsigned f;
		int          idx;
		bit          clear;
		len = zone_len();
		n = r.npages;
		res.code = cpa_pkg::ST_OK;
		res.first_frame = '0;
		case (r.op)
			cpa_pkg::FUNC_ALLOC: begin
				res.code = cpa_pkg::ST_OOM;
				if (n != 0 && n <= len) begin
					for (int unsigned s = 0; s + n <= len; s++) begin
						f = (zone_base + s) & 32'hFFFFF;
						if (r.align && (f & (n - 1)) != 0)
							continue;
						clear = 1;
						for (int unsigned i = 0; i < n; i++)
							if (page_refs[s + i] != 0) clear = 0;
						if (clear) begin
							for (int unsigned i = 0; i < n; i++) begin
								page_refs[s + i] = 1;
								page_owner[s + i] = r.owner;
							end
							res.code = cpa_pkg::ST_OK;
							res.first_frame = f[19:0];
							break;
						end
					end
				end
			end
			cpa_pkg::FUNC_FREE: begin
				for (int unsigned i = 0; i < n; i++) begin
					idx = zone_slot(int'(r.frame) + i);
					if (idx < 0) begin
						if (res.code == cpa_pkg::ST_OK) res.code = cpa_pkg::ST_OUTSIDE;
					end else if (page_refs[idx] == 0) begin
						if (res.code == cpa_pkg::ST_OK) res.code = cpa_pkg::ST_FREE;
					end else begin
						page_refs[idx]--;
					end
				end
			end
			cpa_pkg::FUNC_OWN: begin
				idx = zone_slot(r.frame);
				if (idx < 0)
					res.code = cpa_pkg::ST_OUTSIDE;
				else if (page_refs[idx] != 1 || page_owner[idx] != 0)
					res.code = cpa_pkg::ST_REFUSED;
				else
					page_owner[idx] = r.owner;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic page_req_t make_req(logic [1:0] op, int unsigned n, int unsigned owner,
			bit align, int unsigned frame);
		page_req_t r;
		r.op = op;
		r.npages = n[10:0];
		r.owner = owner[7:0];
		r.align = align;
		r.frame = frame[19:0];
		return r;
	endfunction

	// Random request biased towards the current zone.
	function automatic page_req_t random_req();
		int unsigned len;
		int unsigned pick;
		int unsigned n;
		int unsigned f;
		len = zone_len();
		pick = $urandom_range(0, 99);
		f = zone_base + $urandom_range(0, len + 1);
		if ($urandom_range(0, 9) == 0)
			f = f - $urandom_range(0, 3);
		if (pick < 45) begin
			n = $urandom_range(1, 8);
			case ($urandom_range(0, 9))
				0: n = len;
				1: n = (len <= 64) ? $urandom_range(0, len + 2) : $urandom_range(1, 32);
				2: n = ($urandom_range(0, 1)) ? 1024 : 2047;
				3: n = 1 << $urandom_range(0, 4);
				default: ;
			endcase
			return make_req(cpa_pkg::FUNC_ALLOC, n, $urandom_range(0, 255),
				$urandom_range(0, 1), $urandom);
		end else if (pick < 75) begin
			n = $urandom_range(1, 4);
			if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 40);
			if ($urandom_range(0, 19) == 0) begin
				n = $urandom_range(0, 2047);
				f = $urandom;
			end
			return make_req(cpa_pkg::FUNC_FREE, n, $urandom, $urandom_range(0, 1), f);
		end else if (pick < 95) begin
			if ($urandom_range(0, 19) == 0) f = $urandom;
			return make_req(cpa_pkg::FUNC_OWN, $urandom, $urandom_range(0, 255),
				$urandom_range(0, 1), f);
		end
		return make_req(FUNC_NONE, $urandom, $urandom, $urandom_range(0, 1), $urandom);
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_zone(int unsigned b, int unsigned c);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cpa_pkg::CFG_ZONE_BASE;
		cfg_wdata <= b[19:0];
		@(posedge clk);
		cfg_index <= cpa_pkg::CFG_ZONE_COUNT;
		cfg_wdata <= {9'd0, c[10:0]};
		@(posedge clk);
		cfg_we <= 1'b0;
		zone_base = b & 32'hFFFFF;
		zone_pages = c & 32'h7FF;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Request generation and zone settings.
	initial begin
		int unsigned bases[8];
		int unsigned counts[8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cpa_pkg::CFG_ZONE_BASE;
		cfg_wdata = '0;
		zone_base = 0;
		zone_pages = 0;
		mismatches = 0;
		foreach (page_refs[i]) begin
			page_refs[i] = 0;
			page_owner[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		set_zone(32'h00100, 16);
		// Edge cases on a small zone.
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 17, 1, 0, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 2047, 1, 1, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_OWN, 0, 255, 0, 32'h00100));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_OWN, 0, 7, 0, 32'h00100));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 4, 255, 1, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 3, 9, 1, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 3, 9, 0, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_OWN, 0, 3, 0, 32'h00105));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_OWN, 0, 3, 0, 32'h00102));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_OWN, 0, 3, 0, 32'h000FF));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 4, 0, 0, 32'h000FE));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 2, 0, 0, 32'h00100));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 0, 0, 0, 32'h00100));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 6, 0, 0, 32'h0010E));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 16, 4, 1, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 2047, 0, 1, 32'hFFFFF));
		pending_reqs.push_back(make_req(FUNC_NONE, 2047, 255, 1, 32'hFFFFF));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 1024, 0, 0, 32'h00100));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_ALLOC, 16, 4, 1, 0));
		pending_reqs.push_back(make_req(cpa_pkg::FUNC_FREE, 16, 0, 0, 32'h00100));
		wait_idle();

		bases = '{32'h00000, 32'h00100, 32'hFFFF8, 32'h00040, 32'h00000,
			32'h12345, 32'h00000, 32'hFFFFF};
		counts = '{0, 16, 16, 64, 200, 1024, 2047, 1};
		bases[4] = $urandom;
		foreach (bases[p]) begin
			set_zone(bases[p], counts[p]);
			repeat ((counts[p] == 0 || counts[p] == 1) ? 60 : 185)
				pending_reqs.push_back(random_req());
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		int burst_left;
		int gap_left;
		page_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_NONE;
			page_count <= '0;
			owner_id <= '0;
			align_request <= 1'b0;
			frame_address <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(model_request(offered));
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					r = pending_reqs.pop_front();
					offered = r;
					func <= r.op;
					page_count <= r.npages;
					owner_id <= r.owner;
					align_request <= r.align;
					frame_address <= r.frame;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a stall pattern picked at random from three modes, plus a
	// long hold-off now and then so that the block backs up onto its input.
	always @(posedge clk or negedge arst_n) begin
		int mode;
		int hold_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			mode = 0;
			hold_left = 0;
		end else begin
			if (cycle_count % 500 == 0)
				mode = $urandom_range(0, 2);
			if (cycle_count % 30000 == 3000)
				hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		page_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing awaited: status %0d frame %h",
					$time, status, alloc_frame);
				mismatches++;
			end else begin
				e = awaited_results.pop_front();
				if (status !== e.code) begin
					$display("%0t: status expected %0d, got %0d", $time, e.code, status);
					mismatches++;
				end
				if (alloc_frame !== e.first_frame) begin
					$display("%0t: alloc_frame expected %h, got %h",
						$time, e.first_frame, alloc_frame);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_CAP) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/cpa_pkg.sv
hw/rtl/cpa_ctrl.sv
hw/rtl/cpa_dp.sv
hw/rtl/contiguous_page_allocator_top.sv
tb/sv/tb.sv
